// File: sv/vcbad_pkg.sv
`default_nettype none

package vcbad_pkg;

  // Input word: one host access.
  typedef struct packed {
    logic        kind;
    logic [1:0]  access_size;
    logic [19:0] address;
    logic [31:0] write_data;
    logic        vblank_active;
  } req_t;

  // Output word: read data and interrupt status.
  typedef struct packed {
    logic [31:0] read_data;
    logic        irq_clear;
    logic        vbl_enabled;
  } rsp_t;

  // Access direction and size codes.
  localparam logic       KIND_READ  = 1'b0;
  localparam logic       KIND_WRITE = 1'b1;
  localparam logic [1:0] SIZE_BYTE  = 2'd0;
  localparam logic [1:0] SIZE_HALF  = 2'd1;
  localparam logic [1:0] SIZE_LONG  = 2'd2;

  // Address decode: top nibble of the window for the 64 KB ports, and
  // the 32-byte page of the DAC (0x90000 >> 5).
  localparam logic [3:0]  SEG_CRTC  = 4'h8;
  localparam logic [3:0]  SEG_VBL   = 4'hA;
  localparam logic [3:0]  SEG_SENSE = 4'hD;
  localparam logic [14:0] DAC_PAGE  = 15'h4800;

  // DAC register select, from address bits 3:2.
  localparam logic [1:0] DAC_UNUSED = 2'd0;
  localparam logic [1:0] DAC_ADDR_A = 2'd1;
  localparam logic [1:0] DAC_DATA   = 2'd2;
  localparam logic [1:0] DAC_ADDR_B = 2'd3;

  // Where a read byte comes from once the memories have answered.
  localparam logic [1:0] SRC_CONST = 2'd0;
  localparam logic [1:0] SRC_EVEN  = 2'd1;
  localparam logic [1:0] SRC_ODD   = 2'd2;
  localparam logic [1:0] SRC_PAL   = 2'd3;

  localparam logic [7:0] BYTE_ONES = 8'hFF;

  typedef struct packed {
    logic [1:0] src;
    logic [1:0] lane;
    logic [7:0] value;
  } rd_byte_t;

  // Decoded access carried from the memory stage to the result stage.
  typedef struct packed {
    rd_byte_t [3:0] bytes;
    logic           is_read;
    logic [1:0]     size;
    logic           irq_clear;
    logic           vbl_enabled;
  } s2_info_t;

  // Video memory access: rows of both banks, byte enables and data.
  typedef struct packed {
    logic [16:0]     row_even;
    logic [16:0]     row_odd;
    logic [3:0]      be_even;
    logic [3:0]      be_odd;
    logic [3:0][7:0] data_even;
    logic [3:0][7:0] data_odd;
  } vram_acc_t;

  // Register file and DAC updates of one access.
  typedef struct packed {
    logic             pal_we;
    logic [7:0]       pal_wdata;
    logic [7:0]       paddr_next;
    logic             vbl_disabled_next;
    logic [15:0]      crtc_we;
    logic [15:0][7:0] crtc_wdata;
  } regs_upd_t;

  // Clearing pass status from the video memory to the DAC.
  typedef struct packed {
    logic       active;
    logic       pal_we;
    logic [7:0] pal_index;
  } clr_t;

endpackage

`default_nettype wire

// File: sv/vcbad_decode.sv
`default_nettype none

module vcbad_decode
  import vcbad_pkg::*;
#(
  parameter int VRAM_BYTES = 524288
) (
  input  req_t      item,
  input  logic [7:0] paddr,
  input  logic      vbl_disabled,
  output vram_acc_t vram_acc,
  output regs_upd_t regs_upd,
  output s2_info_t  info
);

  localparam logic [19:0] VRAM_LIMIT = 20'(VRAM_BYTES);

  logic [3:0][19:0] slot_addr;
  logic [3:0]       in_vram;
  logic [3:0]       in_crtc;
  logic [3:0]       in_dac;
  logic [3:0]       in_vbl;
  logic [3:0]       in_sense;
  logic [3:0]       wr_en;
  logic [3:0][7:0]  wr_byte;
  logic             irq;

  // Byte addresses of the access and the region each one falls in.
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      slot_addr[k] = item.address + 20'(k);
      in_vram[k]   = slot_addr[k] < VRAM_LIMIT;
      in_crtc[k]   = slot_addr[k][19:16] == SEG_CRTC;
      in_dac[k]    = slot_addr[k][19:5] == DAC_PAGE;
      in_vbl[k]    = slot_addr[k][19:16] == SEG_VBL;
      in_sense[k]  = slot_addr[k][19:16] == SEG_SENSE;
    end
  end

  // Split a write into byte writes, first byte at the access address.
  always_comb begin
    wr_en   = '0;
    wr_byte = '0;
    if (item.kind == KIND_WRITE) begin
      case (item.access_size)
        SIZE_BYTE: begin
          wr_en      = 4'b0001;
          wr_byte[0] = item.write_data[7:0];
        end
        SIZE_HALF: begin
          wr_en      = 4'b0011;
          wr_byte[0] = item.write_data[15:8];
          wr_byte[1] = item.write_data[7:0];
        end
        SIZE_LONG: begin
          wr_byte = {item.write_data[7:0], item.write_data[15:8],
                     item.write_data[23:16], item.write_data[31:24]};
          if (in_vbl[0]) begin
            wr_en = 4'b0001;
          end else if (in_dac[0]) begin
            wr_en = 4'b1111;
          end else if (in_vram[0]) begin
            // Only an aligned longword reaches video memory.
            wr_en = (item.address[1:0] == 2'b00) ? 4'b1111 : 4'b0000;
          end else if (in_crtc[0]) begin
            wr_en      = 4'b0001;
            wr_byte[0] = item.write_data[7:0];
          end
        end
        default: begin
          wr_en = '0;
        end
      endcase
    end
  end

  // Effects of the byte writes, later bytes taking priority, and the
  // source of each read byte.
  always_comb begin
    vram_acc          = '0;
    vram_acc.row_odd  = item.address[19:3];
    vram_acc.row_even = item.address[19:3] + 17'(item.address[2]);

    regs_upd                   = '0;
    regs_upd.paddr_next        = paddr;
    regs_upd.vbl_disabled_next = vbl_disabled;
    irq                        = 1'b0;

    for (int k = 0; k < 4; k++) begin
      if (wr_en[k]) begin
        // Video memory holds inverted bytes, lane 0 in the top byte.
        if (in_vram[k]) begin
          if (!slot_addr[k][2]) begin
            vram_acc.be_even[~slot_addr[k][1:0]]   = 1'b1;
            vram_acc.data_even[~slot_addr[k][1:0]] = ~wr_byte[k];
          end else begin
            vram_acc.be_odd[~slot_addr[k][1:0]]   = 1'b1;
            vram_acc.data_odd[~slot_addr[k][1:0]] = ~wr_byte[k];
          end
        end
        if (in_vbl[k]) begin
          regs_upd.vbl_disabled_next = slot_addr[k][2];
          if (!slot_addr[k][2]) begin
            irq = 1'b1;
          end
        end
        if (in_crtc[k]) begin
          regs_upd.crtc_we[slot_addr[k][5:2]]    = 1'b1;
          regs_upd.crtc_wdata[slot_addr[k][5:2]] = ~wr_byte[k];
        end
        if (in_dac[k] && (slot_addr[k][1:0] == 2'b00)) begin
          case (slot_addr[k][3:2])
            DAC_ADDR_A, DAC_ADDR_B: begin
              regs_upd.paddr_next = ~wr_byte[k];
            end
            DAC_DATA: begin
              regs_upd.pal_we     = 1'b1;
              regs_upd.pal_wdata  = ~wr_byte[k];
              regs_upd.paddr_next = paddr + 8'd1;
            end
            default: begin
            end
          endcase
        end
      end
    end

    for (int k = 0; k < 4; k++) begin
      info.bytes[k].lane  = slot_addr[k][1:0];
      info.bytes[k].src   = SRC_CONST;
      info.bytes[k].value = BYTE_ONES;
      if (in_vram[k]) begin
        info.bytes[k].src   = slot_addr[k][2] ? SRC_ODD : SRC_EVEN;
        info.bytes[k].value = '0;
      end else if (in_dac[k]) begin
        info.bytes[k].value = '0;
        if (slot_addr[k][1:0] == 2'b00) begin
          case (slot_addr[k][3:2])
            DAC_DATA: begin
              info.bytes[k].src = SRC_PAL;
            end
            DAC_ADDR_A, DAC_ADDR_B: begin
              info.bytes[k].value = ~paddr;
            end
            default: begin
              info.bytes[k].value = '0;
            end
          endcase
        end
      end else if (in_sense[k]) begin
        info.bytes[k].value = item.vblank_active ? 8'h00 : BYTE_ONES;
      end
    end

    info.is_read     = item.kind == KIND_READ;
    info.size        = item.access_size;
    info.irq_clear   = irq;
    info.vbl_enabled = !regs_upd.vbl_disabled_next;
  end

endmodule

`default_nettype wire

// File: sv/vcbad_vram.sv
`default_nettype none

module vcbad_vram
  import vcbad_pkg::*;
#(
  parameter int VRAM_BYTES = 524288
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            commit,
  input  vram_acc_t       acc,
  output clr_t            clr,
  output logic [3:0][7:0] even_q,
  output logic [3:0][7:0] odd_q
);

  localparam int VRAM_WORDS = (VRAM_BYTES + 3) / 4;
  localparam int BANK_DEPTH = (VRAM_WORDS + 1) / 2;
  localparam int BANK_AW    = $clog2(BANK_DEPTH);

  // Even and odd words live in separate banks, so an access that spans
  // two words reads or writes each bank once.
  logic [3:0][7:0] bank_even [BANK_DEPTH];
  logic [3:0][7:0] bank_odd  [BANK_DEPTH];

  logic               clearing;
  logic [BANK_AW-1:0] clr_row;
  logic [BANK_AW-1:0] wa_even;
  logic [BANK_AW-1:0] wa_odd;
  logic [3:0]         be_even;
  logic [3:0]         be_odd;
  logic [3:0][7:0]    wd_even;
  logic [3:0][7:0]    wd_odd;

  // Clearing pass after reset, one row of both banks per cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_row  <= '0;
    end else if (clearing) begin
      clr_row <= clr_row + 1'b1;
      if (clr_row == BANK_AW'(BANK_DEPTH - 1)) begin
        clearing <= 1'b0;
      end
    end
  end

  // The palette is loaded during the first 256 rows of the pass.
  assign clr.active    = clearing;
  assign clr.pal_we    = clearing && (clr_row[BANK_AW-1:8] == '0);
  assign clr.pal_index = clr_row[7:0];

  // Write port select: clearing pass or committed access.
  always_comb begin
    if (clearing) begin
      wa_even = clr_row;
      wa_odd  = clr_row;
      be_even = 4'hF;
      be_odd  = 4'hF;
      wd_even = '0;
      wd_odd  = '0;
    end else begin
      wa_even = acc.row_even[BANK_AW-1:0];
      wa_odd  = acc.row_odd[BANK_AW-1:0];
      be_even = commit ? acc.be_even : 4'h0;
      be_odd  = commit ? acc.be_odd : 4'h0;
      wd_even = acc.data_even;
      wd_odd  = acc.data_odd;
    end
  end

  // Byte-masked writes and registered reads.
  always_ff @(posedge clk) begin
    for (int i = 0; i < 4; i++) begin
      if (be_even[i]) begin
        bank_even[wa_even][i] <= wd_even[i];
      end
      if (be_odd[i]) begin
        bank_odd[wa_odd][i] <= wd_odd[i];
      end
    end
    if (commit) begin
      even_q <= bank_even[acc.row_even[BANK_AW-1:0]];
      odd_q  <= bank_odd[acc.row_odd[BANK_AW-1:0]];
    end
  end

endmodule

`default_nettype wire

// File: sv/vcbad_regs.sv
`default_nettype none

module vcbad_regs
  import vcbad_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       commit,
  input  clr_t       clr,
  input  regs_upd_t  upd,
  output logic [7:0] paddr,
  output logic       vbl_disabled,
  output logic [7:0] pal_q
);

  logic [7:0] palette [256];
  logic [7:0] crtc    [16];
  logic       pal_we;
  logic [7:0] pal_wa;
  logic [7:0] pal_wd;

  // Palette write port: during clearing, 0x00 to entries 0-127 and 0xFF to 128-255, else DAC data.
  always_comb begin
    if (clr.pal_we) begin
      pal_we = 1'b1;
      pal_wa = clr.pal_index;
      pal_wd = {8{clr.pal_index[7]}};
    end else begin
      pal_we = commit && upd.pal_we;
      pal_wa = paddr;
      pal_wd = upd.pal_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (pal_we) begin
      palette[pal_wa] <= pal_wd;
    end
    if (commit) begin
      pal_q <= palette[paddr];
    end
  end

  // DAC address and VBL interrupt disable.
  always_ff @(posedge clk) begin
    if (rst) begin
      paddr        <= '0;
      vbl_disabled <= 1'b1;
    end else if (commit) begin
      paddr        <= upd.paddr_next;
      vbl_disabled <= upd.vbl_disabled_next;
    end
  end

  // CRTC register file, inverted low bytes.
  always_ff @(posedge clk) begin
    for (int i = 0; i < 16; i++) begin
      if (rst) begin
        crtc[i] <= '0;
      end else if (commit && upd.crtc_we[i]) begin
        crtc[i] <= upd.crtc_wdata[i];
      end
    end
  end

endmodule

`default_nettype wire

// File: sv/video_card_bus_access_decoder_unit.sv
`default_nettype none

// Bus slave of a frame-buffer card: one byte, halfword or longword host
// access per word on req, one result word on rsp carrying right-aligned
// read data (zero for writes), the interrupt-drop pulse and the VBL
// enable after the access. An access is accepted every cycle while the
// rsp side takes results; it is registered in s1, then in s2 together
// with the registered reads of the video memory and palette, then on
// rsp. Video memory sits in two banks of 32-bit words split by byte
// address bit 2, each with one read and one byte-masked write per
// cycle. After reset a clearing pass over every row of both banks
// zeroes video memory and loads the palette, with req_ready low.
module video_card_bus_access_decoder_unit
  import vcbad_pkg::*;
#(
  parameter int VRAM_BYTES = 524288
) (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_ready,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_ready,
  output rsp_t rsp
);

  logic            s1_valid;
  req_t            s1;
  logic            s2_valid;
  s2_info_t        s2;
  logic            adv12;
  logic            adv23;
  logic            s1_free;
  logic            s2_free;
  logic            out_free;
  vram_acc_t       vram_acc;
  regs_upd_t       regs_upd;
  s2_info_t        info;
  clr_t            clr;
  logic [3:0][7:0] even_q;
  logic [3:0][7:0] odd_q;
  logic [7:0]      paddr;
  logic            vbl_disabled;
  logic [7:0]      pal_q;
  logic [3:0][7:0] val;
  rsp_t            rsp_next;

  // Pipeline flow control.
  assign out_free  = !rsp_valid || rsp_ready;
  assign adv23     = s2_valid && out_free;
  assign s2_free   = !s2_valid || adv23;
  assign adv12     = s1_valid && s2_free;
  assign s1_free   = !s1_valid || adv12;
  assign req_ready = s1_free && !clr.active;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      if (req_valid && req_ready) begin
        s1_valid <= 1'b1;
      end else if (adv12) begin
        s1_valid <= 1'b0;
      end
      if (adv12) begin
        s2_valid <= 1'b1;
      end else if (adv23) begin
        s2_valid <= 1'b0;
      end
      if (adv23) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid && req_ready) begin
      s1 <= req;
    end
    if (adv12) begin
      s2 <= info;
    end
    if (adv23) begin
      rsp <= rsp_next;
    end
  end

  vcbad_decode #(
    .VRAM_BYTES(VRAM_BYTES)
  ) u_decode (
    .item        (s1),
    .paddr       (paddr),
    .vbl_disabled(vbl_disabled),
    .vram_acc    (vram_acc),
    .regs_upd    (regs_upd),
    .info        (info)
  );

  vcbad_vram #(
    .VRAM_BYTES(VRAM_BYTES)
  ) u_vram (
    .clk   (clk),
    .rst   (rst),
    .commit(adv12),
    .acc   (vram_acc),
    .clr   (clr),
    .even_q(even_q),
    .odd_q (odd_q)
  );

  vcbad_regs u_regs (
    .clk         (clk),
    .rst         (rst),
    .commit      (adv12),
    .clr         (clr),
    .upd         (regs_upd),
    .paddr       (paddr),
    .vbl_disabled(vbl_disabled),
    .pal_q       (pal_q)
  );

  // Pick each read byte from its source; stored data is inverted.
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      case (s2.bytes[k].src)
        SRC_EVEN: val[k] = ~even_q[~s2.bytes[k].lane];
        SRC_ODD:  val[k] = ~odd_q[~s2.bytes[k].lane];
        SRC_PAL:  val[k] = ~pal_q;
        default:  val[k] = s2.bytes[k].value;
      endcase
    end
  end

  // Right-align the read bytes, first byte most significant.
  always_comb begin
    rsp_next.read_data = '0;
    if (s2.is_read) begin
      case (s2.size)
        SIZE_BYTE: rsp_next.read_data = {24'h0, val[0]};
        SIZE_HALF: rsp_next.read_data = {16'h0, val[0], val[1]};
        SIZE_LONG: rsp_next.read_data = {val[0], val[1], val[2], val[3]};
        default:   rsp_next.read_data = '0;
      endcase
    end
    rsp_next.irq_clear   = s2.irq_clear;
    rsp_next.vbl_enabled = s2.vbl_enabled;
  end

endmodule

`default_nettype wire

// File: sv/vcbad_checker.sv
`default_nettype none

module vcbad_checker
  import vcbad_pkg::*;
(
  input logic clk,
  input logic rst,
  input logic req_valid,
  input logic req_ready,
  input logic rsp_valid,
  input logic rsp_ready,
  input rsp_t rsp
);

  logic [2:0] outstanding;
  logic       req_acc;
  logic       rsp_acc;

  assign req_acc = req_valid && req_ready;
  assign rsp_acc = rsp_valid && rsp_ready;

  // Words accepted but not yet delivered.
  always_ff @(posedge clk) begin
    if (rst) begin
      outstanding <= '0;
    end else if (req_acc && !rsp_acc) begin
      outstanding <= outstanding + 3'd1;
    end else if (rsp_acc && !req_acc) begin
      outstanding <= outstanding - 3'd1;
    end
  end

  // Reset starts the clearing pass with nothing in flight.
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !req_ready && !rsp_valid)
    else $error("ready or result after reset");

  // A stalled result holds.
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
    else $error("stalled result changed");

  // No result without an accepted access behind it.
  a_rsp_backed: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> outstanding != 3'd0)
    else $error("result without accepted access");

  // Three register stages bound the words in flight.
  a_depth: assert property (@(posedge clk) disable iff (rst)
    outstanding <= 3'd3)
    else $error("more accesses in flight than pipeline stages");

endmodule

bind video_card_bus_access_decoder_unit vcbad_checker u_checker (.*);

`default_nettype wire
